/* hdl/htfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the bytewise CRC-8 function of the humidity and
// temperature frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int RAW_W   = 16;
  localparam int TEMP_W  = 9;
  localparam int HUM_W   = 7;

  // CRC-8, polynomial x^8+x^5+x^4+1, initial value zero.
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

  // The two low bits of the raw value are status bits.
  localparam logic [RAW_W-1:0] STATUS_MASK = 16'hFFFC;

  // Conversion in fixed point. The numerator is coef * S - offset; the
  // quotient is taken by a 16-bit shift, and for temperature a further
  // division by 100.
  localparam int COEF_W = 15;
  localparam int PROD_W = COEF_W + RAW_W;
  localparam logic [COEF_W-1:0] TEMP_COEF   = 15'd17572;
  localparam logic [COEF_W-1:0] HUM_COEF    = 15'd125;
  localparam logic [PROD_W-1:0] TEMP_OFFSET = 31'd307036160;
  localparam logic [PROD_W-1:0] HUM_OFFSET  = 31'd393216;
  localparam int FRAC_BITS = 16;

  // Magnitude after the shift stays below 2^14.
  localparam int MAG_W = 14;

  // Division by 100 as a multiplication by ceil(2^19 / 100); exact for every
  // magnitude below 43690.
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int RECIP_PROD_W = MAG_W + RECIP_W;
  localparam int QUOT_W = 8;

  // Finished frame handed from the frame tracker to the converter.
  typedef struct packed {
    logic [RAW_W-1:0] s_value;  // raw value with the status bits cleared
    logic             ok;       // received CRC matched
    logic             hum;      // frame kind: 1 humidity, 0 temperature
  } frame_t;

  // One byte through the CRC, most significant bit first.
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/htfd_frame.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_frame
// Input register and frame tracker: follows the byte position, assembles the
// raw value, runs the CRC and hands each finished frame on.
// ----------------------------------------------------------------------------
module htfd_frame (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_ready,
  input  logic [htfd_pkg::BYTE_W-1:0] byte_data,
  input  logic                        byte_start,
  input  logic                        byte_hum,
  output logic                        frm_valid,
  input  logic                        frm_ready,
  output htfd_pkg::frame_t            frm
);
  import htfd_pkg::*;

  localparam logic [1:0] POS_MSB = 2'd0;
  localparam logic [1:0] POS_LSB = 2'd1;
  localparam logic [1:0] POS_CRC = 2'd2;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_start;
  logic              in_hum;

  logic [1:0]        position;
  logic [1:0]        position_next;
  logic [BYTE_W-1:0] crc;
  logic [BYTE_W-1:0] crc_next;
  logic [RAW_W-1:0]  raw;
  logic [RAW_W-1:0]  raw_next;

  logic [1:0]        pos_eff;
  logic [BYTE_W-1:0] crc_eff;
  logic              done;
  logic              proc;

  // The registered byte is processed once the frame slot is free.
  assign proc       = in_valid && (!frm_valid || frm_ready);
  assign byte_ready = !in_valid || proc;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_ready) begin
      in_valid <= byte_valid;
    end
    if (byte_ready && byte_valid) begin
      in_byte  <= byte_data;
      in_start <= byte_start;
      in_hum   <= byte_hum;
    end
  end

  // A frame start, or a position out of range, restarts the frame.
  assign pos_eff = (in_start || position > POS_CRC) ? POS_MSB : position;
  assign crc_eff = (in_start || position > POS_CRC) ? '0 : crc;

  // Position sequencing and CRC update for one byte.
  always_comb begin
    position_next = POS_MSB;
    crc_next      = '0;
    raw_next      = raw;
    done          = 1'b0;
    case (pos_eff)
      POS_MSB: begin
        raw_next      = {in_byte, {BYTE_W{1'b0}}};
        crc_next      = crc8_update('0, in_byte);
        position_next = POS_LSB;
      end
      POS_LSB: begin
        raw_next      = {raw[RAW_W-1:BYTE_W], in_byte};
        crc_next      = crc8_update(crc_eff, in_byte);
        position_next = POS_CRC;
      end
      POS_CRC: begin
        done = 1'b1;
      end
      default: begin
        raw_next      = {in_byte, {BYTE_W{1'b0}}};
        crc_next      = crc8_update('0, in_byte);
        position_next = POS_LSB;
      end
    endcase
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= POS_MSB;
      crc      <= '0;
      raw      <= '0;
    end else if (proc) begin
      position <= position_next;
      crc      <= crc_next;
      raw      <= raw_next;
    end
  end

  // Finished frame register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (!frm_valid || frm_ready) begin
      frm_valid <= proc && done;
    end
    if (proc && done) begin
      frm.s_value <= raw & STATUS_MASK;
      frm.ok      <= (crc_eff == in_byte);
      frm.hum     <= in_hum;
    end
  end

  // The position never leaves the three byte slots.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= POS_CRC)
    else $error("frame position out of range");

  // A processed CRC byte always yields a finished frame.
  a_crc_gives_frame: assert property (@(posedge clk) disable iff (rst)
    proc && pos_eff == POS_CRC |=> frm_valid)
    else $error("CRC byte produced no frame");

  // After a frame the tracker is back at the first byte with a cleared CRC.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    proc && done |=> position == POS_MSB && crc == '0)
    else $error("frame tracker not restarted after CRC byte");

endmodule

/* hdl/htfd_convert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_convert
// Three-stage converter: product, magnitude and quotient. Holds the last
// good temperature and humidity and drives the result register.
// ----------------------------------------------------------------------------
module htfd_convert (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        frm_valid,
  output logic                        frm_ready,
  input  htfd_pkg::frame_t            frm,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [htfd_pkg::TEMP_W-1:0] temperature_c,
  output logic [htfd_pkg::HUM_W-1:0]  humidity_pct,
  output logic                        crc_ok,
  output logic                        was_humidity
);
  import htfd_pkg::*;

  // Product stage.
  logic              p_valid;
  logic [PROD_W-1:0] p_prod;
  logic              p_ok;
  logic              p_hum;
  // Magnitude stage.
  logic              m_valid;
  logic [MAG_W-1:0]  m_mag;
  logic              m_neg;
  logic              m_ok;
  logic              m_hum;

  logic              out_free;
  logic              m_free;
  logic              p_free;
  logic              out_load;

  logic [COEF_W-1:0]       coef;
  logic [PROD_W-1:0]       prod_c;
  logic [PROD_W-1:0]       offset;
  logic                    above;
  logic [PROD_W-1:0]       mag_c;
  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [QUOT_W-1:0]       quot;
  logic signed [TEMP_W-1:0] temp_c;
  logic [HUM_W-1:0]        hum_c;

  logic signed [TEMP_W-1:0] held_temp;
  logic [HUM_W-1:0]         held_hum;

  // Each stage moves on when the one after it is free, so bubbles close up.
  assign out_free  = !out_valid || out_ready;
  assign out_load  = m_valid && out_free;
  assign m_free    = !m_valid || out_free;
  assign p_free    = !p_valid || m_free;
  assign frm_ready = p_free;

  // Numerator product, coefficient chosen by kind.
  assign coef   = frm.hum ? HUM_COEF : TEMP_COEF;
  assign prod_c = PROD_W'(coef) * PROD_W'(frm.s_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= frm_valid;
    end
    if (p_free && frm_valid) begin
      p_prod <= prod_c;
      p_ok   <= frm.ok;
      p_hum  <= frm.hum;
    end
  end

  // Offset subtraction as sign and magnitude, then drop the fraction.
  assign offset = p_hum ? HUM_OFFSET : TEMP_OFFSET;
  assign above  = p_prod >= offset;
  assign mag_c  = above ? (p_prod - offset) : (offset - p_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_free) begin
      m_valid <= p_valid;
    end
    if (m_free && p_valid) begin
      m_mag <= mag_c[FRAC_BITS +: MAG_W];
      m_neg <= !above;
      m_ok  <= p_ok;
      m_hum <= p_hum;
    end
  end

  // Temperature: divide the magnitude by 100 and restore the sign.
  // Humidity: zero below the offset, else the whole part.
  assign recip_prod = RECIP_PROD_W'(m_mag) * RECIP_PROD_W'(RECIP_100);
  assign quot       = recip_prod[RECIP_SHIFT +: QUOT_W];
  assign temp_c     = m_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign hum_c      = m_neg ? '0 : m_mag[HUM_W-1:0];

  // Held values and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_temp <= '0;
      held_hum  <= '0;
    end else begin
      if (out_free) begin
        out_valid <= m_valid;
      end
      if (out_load && m_ok) begin
        if (m_hum) begin
          held_hum <= hum_c;
        end else begin
          held_temp <= temp_c;
        end
      end
    end
    if (out_load) begin
      crc_ok       <= m_ok;
      was_humidity <= m_hum;
    end
  end

  assign temperature_c = held_temp;
  assign humidity_pct  = held_hum;

  // A failed CRC leaves both held values untouched.
  a_fail_keeps: assert property (@(posedge clk) disable iff (rst)
    out_load && !m_ok |=> $stable(held_temp) && $stable(held_hum))
    else $error("held value changed on CRC mismatch");

  // Humidity stays within the sensor's span.
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    held_hum <= HUM_W'(119))
    else $error("held humidity out of range");

endmodule

/* hdl/humidity_temp_frame_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Checks the CRC of three-byte sensor measurement frames and converts the
// raw value to whole degrees Celsius or whole percent relative humidity.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock (raw MSB, raw LSB, CRC) while
// s_axis_tready is high and gives one result per completed frame: an input
// register, the frame tracker register, a product register, a magnitude
// register and the result register form the path. The CRC byte's
// tuser kind bit selects the conversion. On a CRC match the value of that
// kind is updated and held; on a mismatch both held values stay as they were
// and crc_ok is low. A byte with frame_start set always begins a new frame.
// Results that wait at the output do not stop incoming bytes until the
// stages behind the result register are full.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [0] frame_start, [1] is_humidity
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [8:0] temperature_c, [15:9] humidity_pct
  output logic [1:0]  m_axis_tuser    // [0] crc_ok, [1] was_humidity
);
  import htfd_pkg::*;

  logic                     frm_valid;
  logic                     frm_ready;
  frame_t                   frm;
  logic signed [TEMP_W-1:0] temperature_c;
  logic [HUM_W-1:0]         humidity_pct;
  logic                     crc_ok;
  logic                     was_humidity;

  // Byte tracking and CRC.
  htfd_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_axis_tvalid),
    .byte_ready (s_axis_tready),
    .byte_data  (s_axis_tdata),
    .byte_start (s_axis_tuser[0]),
    .byte_hum   (s_axis_tuser[1]),
    .frm_valid  (frm_valid),
    .frm_ready  (frm_ready),
    .frm        (frm)
  );

  // Conversion and held values.
  htfd_convert u_convert (
    .clk           (clk),
    .rst           (rst),
    .frm_valid     (frm_valid),
    .frm_ready     (frm_ready),
    .frm           (frm),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .temperature_c (temperature_c),
    .humidity_pct  (humidity_pct),
    .crc_ok        (crc_ok),
    .was_humidity  (was_humidity)
  );

  // Result packing.
  assign m_axis_tdata = {humidity_pct, temperature_c};
  assign m_axis_tuser = {was_humidity, crc_ok};

endmodule
